FILE: rtl/lfu_pkg.sv
// shared constants, codes and control/status types of the lfu cache table
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 64;
	localparam int COUNT_W    = 32;
	localparam int STAMP_W    = 48;
	localparam int CAP_W      = 5;
	localparam int STATUS_W   = 3;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int USED_W     = $clog2(ENTRIES + 1);
	localparam int CMP_W      = (CAP_W > USED_W) ? CAP_W : USED_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [STATUS_W-1:0] {
		ST_GET_MISS   = 3'd0,
		ST_GET_HIT    = 3'd1,
		ST_SET_EXISTS = 3'd2,
		ST_INSERTED   = 3'd3,
		ST_EVICTED    = 3'd4
	} status_code_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} ctrl_state_t;

	typedef enum logic {
		ACT_GET = 1'b0,
		ACT_SET = 1'b1
	} action_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             commit;
	} lfu_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_blocked;
	} lfu_stat_t;

endpackage

FILE: rtl/lfu_cache_table_core.sv
// top level of the lfu cache table: controller plus datapath
// A fully associative 16-entry key/value cache with least-frequently-used
// replacement (ties broken by oldest stamp, then lowest index). Each item
// is accepted, then walks all ENTRIES entries one at a time through the
// single read port of the entry memory, finishes the last compare and
// ends in a commit step that writes the entry and loads the result
// register. A finished result waits in the output register while the next
// item is accepted and scanned; commit holds only if that register is still
// occupied. capacity may be written only while the block is idle; 0 acts as
// 1 and values above 16 act as 16.
module lfu_cache_table_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [lfu_pkg::KEY_BITS-1:0]   key,
	input  logic [lfu_pkg::VALUE_BITS-1:0] value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lfu_pkg::STATUS_W-1:0]   status,
	output logic [lfu_pkg::VALUE_BITS-1:0] read_value
);
	import lfu_pkg::*;

	lfu_cmd_t  cmd;
	lfu_stat_t stat;

	// sequencer
	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage and compare
	lfu_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.action     (action),
		.key        (key),
		.value      (value),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_value (read_value)
	);

endmodule

FILE: rtl/lfu_ctrl.sv
// controller state machine: accept, scan sequencing and commit of one item
module lfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lfu_pkg::lfu_stat_t stat,
	output lfu_pkg::lfu_cmd_t  cmd
);
	import lfu_pkg::*;

	ctrl_state_t      state_q;
	ctrl_state_t      state_d;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] cnt_d;

	// state and scan counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.rd_en   = 1'b0;
		cmd.rd_addr = cnt_q;
		cmd.commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cnt_d    = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == IDX_W'(ENTRIES - 1)) begin
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (!stat.out_blocked) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/lfu_datapath.sv
// entry storage, scan compare unit, update logic and result register
module lfu_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]      cfg_wdata,
	input  logic                           action,
	input  logic [lfu_pkg::KEY_BITS-1:0]   key,
	input  logic [lfu_pkg::VALUE_BITS-1:0] value,
	input  lfu_pkg::lfu_cmd_t              cmd,
	output lfu_pkg::lfu_stat_t             stat,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lfu_pkg::STATUS_W-1:0]   status,
	output logic [lfu_pkg::VALUE_BITS-1:0] read_value
);
	import lfu_pkg::*;

	// entry memories, undefined until written
	logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
	logic [VALUE_BITS-1:0] value_mem [ENTRIES];
	logic [COUNT_W-1:0]    count_mem [ENTRIES];
	logic [STAMP_W-1:0]    stamp_mem [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;

	logic [CAP_W-1:0]      cap_q;
	logic [STAMP_W-1:0]    seq_q;

	// latched item
	action_t               act_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	// read stage
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [KEY_BITS-1:0]   rd_key_s1;
	logic [VALUE_BITS-1:0] rd_val_s1;
	logic [COUNT_W-1:0]    rd_cnt_s1;
	logic [STAMP_W-1:0]    rd_stamp_s1;

	// scan results
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic [COUNT_W-1:0]    hit_cnt_q;
	logic                  best_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [COUNT_W-1:0]    best_cnt_q;
	logic [STAMP_W-1:0]    best_stamp_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic [USED_W-1:0]     used_q;

	// result register
	logic                  out_valid_q;
	status_code_t          status_q;
	logic [VALUE_BITS-1:0] read_value_q;

	// commit decode
	logic                  cur_valid;
	logic                  better;
	logic [CMP_W-1:0]      cap_ext;
	logic [CMP_W-1:0]      cap_eff;
	logic                  evict;
	logic                  do_touch;
	logic                  do_insert;
	logic                  wr_cnt_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [COUNT_W-1:0]    wr_cnt;
	status_code_t          status_d;
	logic [VALUE_BITS-1:0] read_value_d;

	assign cur_valid = valid_q[rd_idx_s1];
	assign better    = !best_q || (rd_cnt_s1 < best_cnt_q) ||
	                   ((rd_cnt_s1 == best_cnt_q) && (rd_stamp_s1 < best_stamp_q));

	// capacity clamp to 1..ENTRIES
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_ext == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	// commit decode: touch an existing entry or place a new one
	always_comb begin
		evict        = (CMP_W'(used_q) >= cap_eff) && best_q;
		do_touch     = hit_q && (hit_cnt_q != '1);
		do_insert    = (act_q == ACT_SET) && !hit_q;
		wr_cnt_en    = cmd.commit && (do_touch || do_insert);
		wr_addr      = hit_idx_q;
		wr_cnt       = hit_cnt_q + 1'b1;
		read_value_d = '0;
		status_d     = ST_GET_MISS;
		if (do_insert) begin
			wr_addr  = evict ? best_idx_q : free_idx_q;
			wr_cnt   = COUNT_W'(1);
			status_d = evict ? ST_EVICTED : ST_INSERTED;
		end else if (act_q == ACT_SET) begin
			status_d = ST_SET_EXISTS;
		end else if (hit_q) begin
			status_d     = ST_GET_HIT;
			read_value_d = hit_val_q;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action_t'(action);
			key_q <= key;
			val_q <= value;
		end
	end

	// memory write ports
	always_ff @(posedge clk) begin
		if (wr_cnt_en) begin
			count_mem[wr_addr] <= wr_cnt;
			stamp_mem[wr_addr] <= seq_q;
		end
		if (cmd.commit && do_insert) begin
			key_mem[wr_addr]   <= key_q;
			value_mem[wr_addr] <= val_q;
		end
	end

	// memory read port, registered
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_idx_s1   <= cmd.rd_addr;
			rd_key_s1   <= key_mem[cmd.rd_addr];
			rd_val_s1   <= value_mem[cmd.rd_addr];
			rd_cnt_s1   <= count_mem[cmd.rd_addr];
			rd_stamp_s1 <= stamp_mem[cmd.rd_addr];
		end
	end

	// valid bits, sequence counter, read stage flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			seq_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.commit && do_insert) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (wr_cnt_en && (seq_q != '1)) begin
				seq_q <= seq_q + 1'b1;
			end
		end
	end

	// scan compare: key match, lfu candidate, lowest free slot, occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			best_q <= 1'b0;
			free_q <= 1'b0;
			used_q <= '0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			best_q <= 1'b0;
			free_q <= 1'b0;
			used_q <= '0;
		end else if (rd_vld_s1) begin
			if (cur_valid) begin
				used_q <= used_q + 1'b1;
				if (!hit_q && (rd_key_s1 == key_q)) begin
					hit_q <= 1'b1;
				end
				if (better) begin
					best_q <= 1'b1;
				end
			end else if (!free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	// scan payload registers
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && cur_valid) begin
			if (!hit_q && (rd_key_s1 == key_q)) begin
				hit_idx_q <= rd_idx_s1;
				hit_val_q <= rd_val_s1;
				hit_cnt_q <= rd_cnt_s1;
			end
			if (better) begin
				best_idx_q   <= rd_idx_s1;
				best_cnt_q   <= rd_cnt_s1;
				best_stamp_q <= rd_stamp_s1;
			end
		end
		if (rd_vld_s1 && !cur_valid && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q     <= status_d;
			read_value_q <= read_value_d;
		end
	end

	assign stat.out_blocked = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign read_value       = read_value_q;

	// a result is never overwritten while it still waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && !out_ready))
		else $error("result register overwritten while pending");

	// a new key without eviction always has a free slot
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && do_insert && !evict) |-> free_q)
		else $error("insert found no free slot");

	// the sequence counter never moves backward
	a_seq_mono: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q >= $past(seq_q))
		else $error("sequence counter decreased");

	// scan reads do not overlap a commit write
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!cmd.rd_en && !rd_vld_s1))
		else $error("commit during scan");

endmodule

FILE: tb/tb_lfu_cache_table_core.sv
`timescale 1ns / 100ps
// self-checking testbench for the lfu cache table core: directed rows, then random access phases
module tb_lfu_cache_table_core;
	import lfu_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 140;
	localparam int POOL_MAX     = 24;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [63:0] ONES = '1;

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		action_t            act;
		logic [63:0]        k;
		logic [63:0]        v;
		bit                 typed;
		status_code_t       st;
		logic [63:0]        rv;
	} plan_row_t;

	typedef struct packed {
		status_code_t          st;
		logic [VALUE_BITS-1:0] rv;
	} lfu_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CAP_W-1:0]      cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	action_t               action;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;
	logic                  out_valid;
	logic                  out_ready;
	logic [STATUS_W-1:0]   status;
	logic [VALUE_BITS-1:0] read_value;

	// shadow copy of the cache table
	logic                  tbl_valid [ENTRIES];
	logic [KEY_BITS-1:0]   tbl_key   [ENTRIES];
	logic [VALUE_BITS-1:0] tbl_val   [ENTRIES];
	logic [COUNT_W-1:0]    tbl_count [ENTRIES];
	logic [STAMP_W-1:0]    tbl_stamp [ENTRIES];
	logic [STAMP_W-1:0]    seq_next;
	logic [CAP_W-1:0]      cap_reg;

	lfu_result_t pending_results[$];
	plan_row_t   plan[$];
	logic [63:0] pool_keys [POOL_MAX];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          hold_req = 1'b0;
	bit          sender_steady = 1'b0;

	lfu_cache_table_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.read_value(read_value)
	);

	always #CLK_HALF clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
		mismatches++;
	endtask

	// sequence stamp, stops at its maximum
	function automatic logic [STAMP_W-1:0] take_stamp();
		logic [STAMP_W-1:0] s;
		s = seq_next;
		if (seq_next != '1)
			seq_next = seq_next + 1'b1;
		return s;
	endfunction

	// a hit raises the use count; a saturated count keeps its stamp
	function automatic void bump_use(input int idx);
		if (tbl_count[idx] != '1) begin
			tbl_count[idx] = tbl_count[idx] + 1'b1;
			tbl_stamp[idx] = take_stamp();
		end
	endfunction

	// expected result of one get or set, updating the shadow table
	function automatic void predict_access(input action_t act, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v, output status_code_t st,
			output logic [VALUE_BITS-1:0] rv);
		int hit;
		int slot;
		int used;
		int eff_cap;
		hit = -1;
		slot = -1;
		used = 0;
		eff_cap = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
		st = ST_GET_MISS;
		rv = '0;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && tbl_valid[i] && tbl_key[i] == k)
				hit = i;
		if (act == ACT_GET) begin
			if (hit >= 0) begin
				bump_use(hit);
				st = ST_GET_HIT;
				rv = tbl_val[hit];
			end
		end else if (hit >= 0) begin
			bump_use(hit);
			st = ST_SET_EXISTS;
		end else begin
			for (int i = 0; i < ENTRIES; i++)
				if (tbl_valid[i])
					used++;
			st = ST_INSERTED;
			// victim: lowest count, then oldest stamp, then lowest index
			if (used >= eff_cap) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (!tbl_valid[i])
						continue;
					if (slot < 0 || tbl_count[i] < tbl_count[slot] ||
							(tbl_count[i] == tbl_count[slot] &&
							tbl_stamp[i] < tbl_stamp[slot]))
						slot = i;
				end
				if (slot >= 0) begin
					tbl_valid[slot] = 1'b0;
					st = ST_EVICTED;
				end
			end
			if (slot < 0)
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!tbl_valid[i])
						slot = i;
			tbl_valid[slot] = 1'b1;
			tbl_key[slot]   = k;
			tbl_val[slot]   = v;
			tbl_count[slot] = COUNT_W'(1);
			tbl_stamp[slot] = take_stamp();
		end
	endfunction

	function automatic void add_row(input row_kind_t kind, input action_t act,
			input logic [63:0] k, input logic [63:0] v, input bit typed,
			input status_code_t st, input logic [63:0] rv);
		plan_row_t row;
		row  = '{kind, act, k, v, typed, st, rv};
		plan = {plan, row};
	endfunction

	// offer one item, predict on acceptance, then possibly idle for a random gap
	task automatic send_item(input action_t act, input logic [63:0] k, input logic [63:0] v,
			input bit typed, input status_code_t tst, input logic [63:0] trv);
		status_code_t st;
		logic [VALUE_BITS-1:0] rv;
		lfu_result_t res;
		int r;
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		action   <= act;
		key      <= k;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_access(act, k, v, st, rv);
		if (typed) begin
			st = tst;
			rv = trv;
		end
		res = '{st, rv};
		pending_results = {pending_results, res};
		r = $urandom_range(0, 19);
		if (sender_steady || r < 10)
			gap = 0;
		else if (r < 18)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop offering and wait until every pending result has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		cap_reg = cap;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		lfu_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending", read_value, '0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report_mismatch("status", 64'(status), 64'(want.st));
				if (read_value !== want.rv)
					report_mismatch("read_value", read_value, want.rv);
			end
		end
	end

	// receiver: ready stretches, short stalls, rare long stalls, one forced hold-off
	initial begin
		int seg;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				@(negedge clk);
				out_ready <= 1'b0;
				for (int c = 1; c < HOLD_CYCLES; c++)
					@(negedge clk);
				hold_req = 1'b0;
			end
			seg = $urandom_range(0, 9);
			@(negedge clk);
			if (seg < 3) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(10, 60) - 1) @(negedge clk);
			end else if (seg < 9) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(negedge clk);
				@(negedge clk);
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 4) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(20, 60) - 1) @(negedge clk);
			end
		end
	end

	// stimulus
	initial begin
		logic [CAP_W-1:0] cap;
		logic [63:0] k;
		logic [63:0] v;
		int eff_cap;
		int pool_n;
		int r;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		action    = ACT_GET;
		key       = '0;
		value     = '0;
		for (int i = 0; i < ENTRIES; i++)
			tbl_valid[i] = 1'b0;
		seq_next = '0;
		cap_reg  = CAP_RESET;

		// directed rows: kind, action, key, value (or capacity), typed, status, read value
		add_row(ROW_ITEM, ACT_GET, 64'h0, 64'h0, 1, ST_GET_MISS, 64'h0);
		add_row(ROW_ITEM, ACT_SET, 64'h0, ONES, 1, ST_INSERTED, 64'h0);
		add_row(ROW_ITEM, ACT_GET, 64'h0, 64'h0, 1, ST_GET_HIT, ONES);
		// existing key keeps its stored value
		add_row(ROW_ITEM, ACT_SET, 64'h0, 64'h5, 1, ST_SET_EXISTS, 64'h0);
		add_row(ROW_ITEM, ACT_GET, 64'h0, 64'h0, 1, ST_GET_HIT, ONES);
		add_row(ROW_ITEM, ACT_SET, ONES, 64'h0, 1, ST_INSERTED, 64'h0);
		add_row(ROW_ITEM, ACT_GET, ONES, 64'h0, 1, ST_GET_HIT, 64'h0);
		add_row(ROW_ITEM, ACT_SET, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			0, ST_GET_MISS, 64'h0);
		add_row(ROW_ITEM, ACT_SET, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			0, ST_GET_MISS, 64'h0);
		add_row(ROW_ITEM, ACT_GET, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0, 0, ST_GET_MISS, 64'h0);
		// capacity lowered below occupancy: one eviction per insert
		add_row(ROW_CFG, ACT_GET, 64'h0, 64'd2, 0, ST_GET_MISS, 64'h0);
		add_row(ROW_ITEM, ACT_SET, 64'h1234, 64'h77, 1, ST_EVICTED, 64'h0);
		add_row(ROW_ITEM, ACT_SET, 64'h4321, 64'h88, 1, ST_EVICTED, 64'h0);
		add_row(ROW_ITEM, ACT_GET, 64'h1234, 64'h0, 1, ST_GET_MISS, 64'h0);
		add_row(ROW_ITEM, ACT_GET, 64'h5555_5555_5555_5555, 64'h0, 1, ST_GET_MISS, 64'h0);
		// capacity zero acts as one
		add_row(ROW_CFG, ACT_GET, 64'h0, 64'd0, 0, ST_GET_MISS, 64'h0);
		add_row(ROW_ITEM, ACT_SET, 64'h9, 64'h99, 1, ST_EVICTED, 64'h0);
		add_row(ROW_ITEM, ACT_GET, 64'h9, 64'h0, 0, ST_GET_MISS, 64'h0);
		// equal counts: the entry that reached its count first goes
		add_row(ROW_ITEM, ACT_SET, 64'hB, 64'hBB, 1, ST_EVICTED, 64'h0);
		add_row(ROW_ITEM, ACT_GET, ONES, 64'h0, 1, ST_GET_MISS, 64'h0);
		add_row(ROW_ITEM, ACT_GET, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0, 0, ST_GET_MISS, 64'h0);
		// capacity above the table size acts as the table size
		add_row(ROW_CFG, ACT_GET, 64'h0, 64'd31, 0, ST_GET_MISS, 64'h0);
		add_row(ROW_ITEM, ACT_SET, 64'hC, ONES, 1, ST_INSERTED, 64'h0);
		add_row(ROW_ITEM, ACT_GET, 64'hB, 64'h0, 0, ST_GET_MISS, 64'h0);
		add_row(ROW_ITEM, ACT_GET, 64'hC, 64'h0, 1, ST_GET_HIT, ONES);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed walk
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_capacity(plan[i].v[CAP_W-1:0]);
			else
				send_item(plan[i].act, plan[i].k, plan[i].v, plan[i].typed,
					plan[i].st, plan[i].rv);
		end

		// random phases, each with its own capacity and key pool
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: cap = 5'd16;
				1: cap = CAP_W'($urandom_range(3, 8));
				2: cap = 5'd1;
				3: cap = CAP_W'($urandom_range(0, 31));
				4: cap = 5'd16;
				default: cap = CAP_W'($urandom_range(9, 15));
			endcase
			write_capacity(cap);
			eff_cap = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : int'(cap);
			pool_n = eff_cap + $urandom_range(1, 6);
			if (pool_n > POOL_MAX)
				pool_n = POOL_MAX;
			for (int i = 0; i < POOL_MAX; i++)
				pool_keys[i] = {$urandom, $urandom};
			sender_steady = (ph == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while items keep coming
				if (ph == 1 && n == 20)
					hold_req = 1'b1;
				// sender pause until the table has drained
				if (ph == 3 && n == 70)
					settle();
				r = $urandom_range(0, 19);
				if (r < 17)
					k = pool_keys[$urandom_range(0, pool_n - 1)];
				else if (r == 17)
					k = {$urandom, $urandom};
				else if (r == 18)
					k = '0;
				else
					k = ONES;
				r = $urandom_range(0, 19);
				if (r < 18)
					v = {$urandom, $urandom};
				else if (r == 18)
					v = '0;
				else
					v = ONES;
				send_item(action_t'($urandom_range(0, 1)), k, v, 0, ST_GET_MISS, '0);
			end
		end
		sender_steady = 1'b0;

		settle();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_datapath.sv
rtl/lfu_cache_table_core.sv
tb/tb_lfu_cache_table_core.sv
